>>> rtl/dit_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dit_pkg
// shared types, register codes and reset values of the drain interval timer
// ----------------------------------------------------------------------------
package dit_pkg;

    localparam int CFG_W      = 20;
    localparam int DAYS_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int COUNT_BITS_DEF = 21;

    localparam logic [CFG_W-1:0]  RST_INTERVAL  = CFG_W'(86400);
    localparam logic [CFG_W-1:0]  RST_EXTEND    = CFG_W'(3600);
    localparam logic [CFG_W-1:0]  RST_REUSE     = CFG_W'(7200);
    localparam logic [DAYS_W-1:0] RST_IDLE_DAYS = DAYS_W'(7);
    localparam logic              RST_DRAIN_EN  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INTERVAL  = 3'd0,
        REG_EXTEND    = 3'd1,
        REG_REUSE     = 3'd2,
        REG_IDLE_DAYS = 3'd3,
        REG_DRAIN_EN  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0]  interval_seconds;
        logic [CFG_W-1:0]  extend_window;
        logic [CFG_W-1:0]  reuse_window;
        logic [DAYS_W-1:0] idle_days;
        logic              drain_enable;
    } t_cfg;

    typedef struct packed {
        logic              start_drain;
        logic              interval_expired;
        logic [DAYS_W-1:0] days_left;
    } t_result;

endpackage : dit_pkg
`default_nettype wire

>>> rtl/dit_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dit_in_if
// tick channel: valid/ready handshake with the activity and condition flags
// ----------------------------------------------------------------------------
interface dit_in_if;
    logic valid;
    logic ready;
    logic user_active;
    logic conditions_ok;

    modport source (output valid, output user_active, output conditions_ok, input ready);
    modport sink   (input valid, input user_active, input conditions_ok, output ready);
endinterface : dit_in_if
`default_nettype wire

>>> rtl/dit_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dit_out_if
// result channel: valid/ready handshake with drain start, expiry and day count
// ----------------------------------------------------------------------------
interface dit_out_if;
    logic       valid;
    logic       ready;
    logic       start_drain;
    logic       interval_expired;
    logic [7:0] days_left;

    modport source (output valid, output start_drain, output interval_expired,
                    output days_left, input ready);
    modport sink   (input valid, input start_drain, input interval_expired,
                    input days_left, output ready);
endinterface : dit_out_if
`default_nettype wire

>>> rtl/dit_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dit_step
// next state and result of the interval counters for one tick
// ----------------------------------------------------------------------------
module dit_step
    import dit_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire t_cfg                   i_cfg,
    input  wire logic                   i_user_active,
    input  wire logic                   i_conditions_ok,
    input  wire logic [COUNT_BITS-1:0]  i_target,
    input  wire logic [COUNT_BITS-1:0]  i_elapsed,
    input  wire logic [DAYS_W-1:0]      i_days,
    output logic      [COUNT_BITS-1:0]  o_target,
    output logic      [COUNT_BITS-1:0]  o_elapsed,
    output logic      [DAYS_W-1:0]      o_days,
    output t_result                     o_result
);

    localparam int EXT_W = ((COUNT_BITS > CFG_W + 1) ? COUNT_BITS : CFG_W + 1) + 1;
    localparam logic [EXT_W-1:0] CNT_MAX =
        {{(EXT_W-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

    function automatic logic [COUNT_BITS-1:0] sat_count(input logic [EXT_W-1:0] v);
        logic [COUNT_BITS-1:0] r;
        if (v > CNT_MAX) begin
            r = {COUNT_BITS{1'b1}};
        end else begin
            r = v[COUNT_BITS-1:0];
        end
        return r;
    endfunction

    logic [EXT_W-1:0]      w_tgt_x;
    logic [EXT_W-1:0]      w_remain_x;
    logic [EXT_W-1:0]      w_ext_x;
    logic [EXT_W-1:0]      w_limit_x;
    logic                  w_have;
    logic                  w_reuse_hit;
    logic                  w_ext_hit;
    logic [DAYS_W-1:0]     w_days1;
    logic [COUNT_BITS-1:0] w_tgt1;
    logic                  w_expired;

    always_comb begin
        w_tgt_x    = EXT_W'(i_target);
        w_ext_x    = EXT_W'(i_cfg.extend_window);
        w_limit_x  = EXT_W'(i_cfg.interval_seconds) + w_ext_x;
        w_have     = (i_target >= i_elapsed);
        w_remain_x = EXT_W'(i_target - i_elapsed);

        // activity near the end of the interval keeps the unit in use
        w_reuse_hit = w_have && i_user_active &&
                      (w_remain_x <= EXT_W'(i_cfg.reuse_window));
        w_days1 = w_reuse_hit ? i_cfg.idle_days : i_days;

        // one extension at most: only while the target is below interval plus extension
        w_ext_hit = w_have && i_user_active && (w_remain_x <= w_ext_x) &&
                    (w_tgt_x < w_limit_x);
        w_tgt1 = w_ext_hit ? sat_count(w_tgt_x + w_ext_x) : i_target;

        w_expired = !(w_tgt1 > i_elapsed);
        if (!w_expired) begin
            o_target  = w_tgt1;
            o_elapsed = i_elapsed + COUNT_BITS'(1);
            o_days    = w_days1;
        end else begin
            o_target = sat_count(EXT_W'(i_cfg.interval_seconds));
            if (w_days1 != '0) begin
                o_elapsed = '0;
                o_days    = w_days1 - DAYS_W'(1);
            end else begin
                // unused too long: next interval starts early
                o_elapsed = sat_count(w_ext_x);
                o_days    = i_cfg.idle_days;
            end
        end

        o_result.start_drain      = w_expired && i_cfg.drain_enable &&
                                    i_conditions_ok && !i_user_active;
        o_result.interval_expired = w_expired;
        o_result.days_left        = o_days;
    end

endmodule : dit_step
`default_nettype wire

>>> rtl/drain_interval_timer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drain_interval_timer_core
// periodic half-drain interval timer driven by one-second tick items
// ----------------------------------------------------------------------------
// an accepted tick loads the input register; counter update and result
//   register load when the input stage advances, held while a result stalls
// throughput: one tick per cycle while results are taken; a tick is taken while a result waits
// reset: synchronous active-low; config registers go to their defaults, target
//   loads the default interval, elapsed count clears, day count loads idle days
module drain_interval_timer_core
    import dit_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    dit_in_if.sink                    i_item,
    dit_out_if.source                 o_result,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam int EXT_W = ((COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W) + 1;
    localparam logic [EXT_W-1:0] CNT_MAX =
        {{(EXT_W-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

    // interval loaded into the target saturates at the counter range
    function automatic logic [COUNT_BITS-1:0] sat_interval(input logic [CFG_W-1:0] v);
        logic [EXT_W-1:0]      vx;
        logic [COUNT_BITS-1:0] r;
        vx = EXT_W'(v);
        if (vx > CNT_MAX) begin
            r = {COUNT_BITS{1'b1}};
        end else begin
            r = vx[COUNT_BITS-1:0];
        end
        return r;
    endfunction

    // configuration registers
    t_cfg                  r_cfg;

    // interval state
    logic [COUNT_BITS-1:0] r_target;
    logic [COUNT_BITS-1:0] r_elapsed;
    logic [DAYS_W-1:0]     r_days;

    // input stage
    logic                  r_in_valid;
    logic                  r_in_active;
    logic                  r_in_ok;

    // result stage
    logic                  r_out_valid;
    t_result               r_out;

    // step outputs
    logic [COUNT_BITS-1:0] n_target;
    logic [COUNT_BITS-1:0] n_elapsed;
    logic [DAYS_W-1:0]     n_days;
    t_result               n_out;

    logic                  w_in_take;
    logic                  w_adv;

    // the input stage moves on whenever the result slot is free or draining
    assign w_adv     = r_in_valid && (!r_out_valid || o_result.ready);
    assign w_in_take = i_item.valid && i_item.ready;

    assign i_item.ready = !r_in_valid || w_adv;

    assign o_result.valid            = r_out_valid;
    assign o_result.start_drain      = r_out.start_drain;
    assign o_result.interval_expired = r_out.interval_expired;
    assign o_result.days_left        = r_out.days_left;

    dit_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .i_cfg           (r_cfg),
        .i_user_active   (r_in_active),
        .i_conditions_ok (r_in_ok),
        .i_target        (r_target),
        .i_elapsed       (r_elapsed),
        .i_days          (r_days),
        .o_target        (n_target),
        .o_elapsed       (n_elapsed),
        .o_days          (n_days),
        .o_result        (n_out)
    );

    // configuration writes; an interval write also restarts the interval
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interval_seconds <= RST_INTERVAL;
            r_cfg.extend_window    <= RST_EXTEND;
            r_cfg.reuse_window     <= RST_REUSE;
            r_cfg.idle_days        <= RST_IDLE_DAYS;
            r_cfg.drain_enable     <= RST_DRAIN_EN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_INTERVAL:  r_cfg.interval_seconds <= i_cfg_data;
                REG_EXTEND:    r_cfg.extend_window    <= i_cfg_data;
                REG_REUSE:     r_cfg.reuse_window     <= i_cfg_data;
                REG_IDLE_DAYS: r_cfg.idle_days        <= i_cfg_data[DAYS_W-1:0];
                REG_DRAIN_EN:  r_cfg.drain_enable     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // interval counters: config restart, else one update per tick item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= sat_interval(RST_INTERVAL);
            r_elapsed <= '0;
            r_days    <= RST_IDLE_DAYS;
        end else if (i_cfg_we && (i_cfg_idx == REG_INTERVAL)) begin
            r_target  <= sat_interval(i_cfg_data);
            r_elapsed <= '0;
        end else if (w_adv) begin
            r_target  <= n_target;
            r_elapsed <= n_elapsed;
            r_days    <= n_days;
        end
    end

    // input stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    // input stage payload
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_active <= i_item.user_active;
            r_in_ok     <= i_item.conditions_ok;
        end
    end

    // result stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result stage payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

endmodule : drain_interval_timer_core
`default_nettype wire

>>> verif/drain_interval_timer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// drain_interval_timer_core_tb
// self-checking bench for the drain interval timer: tick items go in through
// a valid/ready channel with random gaps, every result is matched in order
// against a cycle-free software copy of the timer, across directed register
// settings and randomized interval phases with random output back-pressure
// ----------------------------------------------------------------------------
module drain_interval_timer_core_tb;
    import dit_pkg::*;

    localparam int CNT_W          = COUNT_BITS_DEF;
    localparam int RESULT_LATENCY = 2;
    localparam int SETTLE_CYCLES  = RESULT_LATENCY + 4;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_TICKS   = 1900;

    logic i_clk;
    logic i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    dit_in_if  in_if ();
    dit_out_if out_if ();

    drain_interval_timer_core #(
        .COUNT_BITS (CNT_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (in_if),
        .o_result   (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // 2 ns clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // timer copy: registers and counters as the block should hold them
    // ------------------------------------------------------------------------
    t_cfg              timer_cfg;
    logic [CNT_W-1:0]  timer_target;
    logic [CNT_W-1:0]  timer_elapsed;
    logic [DAYS_W-1:0] timer_days;

    // results still owed by the block, oldest first
    t_result due_results[$];

    int mismatches;
    int ticks_sent;
    int results_seen;
    int expiries_seen;
    int drains_seen;
    int out_hold;
    bit smooth;            // no gaps and no stalls in this stretch

    function automatic logic [CNT_W-1:0] clamp_count(logic [63:0] v);
        logic [63:0] top;
        top = (64'd1 << CNT_W) - 64'd1;
        return (v > top) ? top[CNT_W-1:0] : v[CNT_W-1:0];
    endfunction

    function automatic void timer_reset();
        timer_cfg.interval_seconds = RST_INTERVAL;
        timer_cfg.extend_window    = RST_EXTEND;
        timer_cfg.reuse_window     = RST_REUSE;
        timer_cfg.idle_days        = RST_IDLE_DAYS;
        timer_cfg.drain_enable     = RST_DRAIN_EN;
        timer_target  = clamp_count(64'(RST_INTERVAL));
        timer_elapsed = '0;
        timer_days    = RST_IDLE_DAYS;
    endfunction

    function automatic void timer_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            REG_INTERVAL: begin
                // only the interval reloads the counters
                timer_cfg.interval_seconds = data;
                timer_target  = clamp_count(64'(data));
                timer_elapsed = '0;
            end
            REG_EXTEND:    timer_cfg.extend_window = data;
            REG_REUSE:     timer_cfg.reuse_window  = data;
            REG_IDLE_DAYS: timer_cfg.idle_days     = data[DAYS_W-1:0];
            REG_DRAIN_EN:  timer_cfg.drain_enable  = data[0];
            default: ;     // unknown index leaves everything alone
        endcase
    endfunction

    // one tick through the timer; returns what the block must report
    function automatic t_result timer_tick(logic active, logic ok);
        t_result     res;
        logic        in_window;
        logic        expired;
        logic [63:0] remain;
        logic [63:0] ceiling;
        in_window = (timer_target >= timer_elapsed);
        remain    = in_window ? 64'(timer_target) - 64'(timer_elapsed) : 64'd0;
        ceiling   = 64'(timer_cfg.interval_seconds) + 64'(timer_cfg.extend_window);

        // activity near the target: the dispenser is in use, keep the day count full
        if (in_window && remain <= 64'(timer_cfg.reuse_window) && active)
            timer_days = timer_cfg.idle_days;

        // activity in the last window pushes the target out, once at most
        if (in_window && remain <= 64'(timer_cfg.extend_window) && active
                && 64'(timer_target) < ceiling)
            timer_target = clamp_count(64'(timer_target) + 64'(timer_cfg.extend_window));

        if (timer_target > timer_elapsed) begin
            expired       = 1'b0;
            timer_elapsed = timer_elapsed + 1'b1;
        end else begin
            expired       = 1'b1;
            timer_target  = clamp_count(64'(timer_cfg.interval_seconds));
            timer_elapsed = '0;
            if (timer_days != '0) begin
                timer_days = timer_days - 1'b1;
            end else begin
                // unused for too long: reload and start the next interval early
                timer_days    = timer_cfg.idle_days;
                timer_elapsed = clamp_count(64'(timer_cfg.extend_window));
            end
        end

        res.start_drain      = expired && timer_cfg.drain_enable && ok && !active;
        res.interval_expired = expired;
        res.days_left        = timer_days;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // mismatch reporting: first few in full, the rest only counted
    // ------------------------------------------------------------------------
    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s", $time, msg);
    endfunction

    // ------------------------------------------------------------------------
    // result side: random stalls, in-order field compare
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            out_hold = 0;
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got.start_drain      = out_if.start_drain;
                got.interval_expired = out_if.interval_expired;
                got.days_left        = out_if.days_left;
                results_seen++;
                if (got.interval_expired) expiries_seen++;
                if (got.start_drain) drains_seen++;
                if (due_results.size() == 0) begin
                    note_mismatch($sformatf("result with nothing expected: start %0b expired %0b days %0d",
                        got.start_drain, got.interval_expired, got.days_left));
                end else begin
                    want = due_results.pop_front();
                    if (got.start_drain !== want.start_drain)
                        note_mismatch($sformatf("start_drain expected %0b actual %0b",
                            want.start_drain, got.start_drain));
                    if (got.interval_expired !== want.interval_expired)
                        note_mismatch($sformatf("interval_expired expected %0b actual %0b",
                            want.interval_expired, got.interval_expired));
                    if (got.days_left !== want.days_left)
                        note_mismatch($sformatf("days_left expected %0d actual %0d",
                            want.days_left, got.days_left));
                end
                // draw the stall before the next result
                out_hold = smooth ? 0 : $urandom_range(0, 4);
            end else if (out_hold > 0) begin
                out_hold--;
            end
            out_if.ready <= (out_hold == 0);
        end
    end

    // ------------------------------------------------------------------------
    // tick side
    // ------------------------------------------------------------------------

    // offer one tick after a random gap, hold it until taken, then predict
    task automatic send_tick(input logic active, input logic ok);
        int gap;
        gap = smooth ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.user_active   <= active;
        in_if.conditions_ok <= ok;
        do @(posedge i_clk); while (!in_if.ready);
        // valid stays up here; the next call or the settle decides
        due_results.push_back(timer_tick(active, ok));
        ticks_sent++;
    endtask

    // stop offering ticks and let every owed result come out
    task automatic settle_timer();
        in_if.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write, only called with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        timer_write(idx, data);
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset values: long default interval, no expiry, activity far from the target
    task automatic test_power_on_defaults();
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        settle_timer();
    endtask

    // short interval: drain on expiry, a tick with bad conditions, then
    // extension and day reload inside the windows under an active user
    task automatic test_expiry_drain();
        write_reg(REG_EXTEND, CFG_W'(1));
        write_reg(REG_REUSE, CFG_W'(2));
        write_reg(REG_IDLE_DAYS, CFG_W'(1));
        write_reg(REG_DRAIN_EN, CFG_W'(1));
        write_reg(REG_INTERVAL, CFG_W'(3));
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);    // expiry with a clean drain
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);    // activity in the reuse window
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);    // no expiry: the extension moved the target out
        settle_timer();
    endtask

    // day count runs out with the early-start offset past the whole interval
    task automatic test_early_start();
        write_reg(REG_IDLE_DAYS, CFG_W'(0));
        write_reg(REG_EXTEND, CFG_W'(5));
        write_reg(REG_REUSE, CFG_W'(0));
        write_reg(REG_INTERVAL, CFG_W'(3));
        repeat (8) send_tick(1'b0, 1'b1);
        settle_timer();
    endtask

    // widest and narrowest register values, plus writes to unused indexes
    task automatic test_register_extremes();
        write_reg(REG_INTERVAL, '1);
        write_reg(REG_EXTEND, '1);
        write_reg(REG_REUSE, '1);
        write_reg(REG_IDLE_DAYS, CFG_W'(8'hFF));
        send_tick(1'b1, 1'b1);    // whole interval is inside both windows
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        settle_timer();
        write_reg(REG_DRAIN_EN, CFG_W'(0));
        write_reg(REG_EXTEND, CFG_W'(0));
        write_reg(REG_REUSE, CFG_W'(0));
        write_reg(REG_IDLE_DAYS, CFG_W'(0));
        write_reg(REG_INTERVAL, CFG_W'(1));
        for (int k = 1; k <= 3; k++)
            write_reg(CFG_IDX_W'(REG_DRAIN_EN + k), '1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);    // expiry with draining switched off
        send_tick(1'b1, 1'b1);
        settle_timer();
    endtask

    // random phases: fresh register settings, activity density and flow
    // behavior per phase, mostly short intervals so expiries are frequent
    task automatic test_random_intervals(input int n_ticks);
        int               sent;
        int               burst;
        int               act_pct;
        int               ok_pct;
        int               pause_at;
        bit               wide;
        bit               wide_last;
        logic [CFG_W-1:0] interval;
        logic [CFG_W-1:0] extend;
        logic [CFG_W-1:0] reuse;
        sent      = 0;
        wide_last = 1'b1;         // the extremes test left a short interval, but force a write
        while (sent < n_ticks) begin
            wide = ($urandom_range(0, 7) == 0);
            if (wide) begin
                interval = CFG_W'($urandom_range(1, 20'hFFFFF));
                extend   = CFG_W'($urandom);
                reuse    = CFG_W'($urandom);
            end else begin
                interval = CFG_W'($urandom_range(1, 24));
                extend   = CFG_W'($urandom_range(0, interval + 3));
                reuse    = CFG_W'($urandom_range(0, interval + 6));
            end
            // registers are left as they were now and then
            if (wide || wide_last || $urandom_range(0, 3) != 0) write_reg(REG_INTERVAL, interval);
            if ($urandom_range(0, 3) != 0) write_reg(REG_EXTEND, extend);
            if ($urandom_range(0, 3) != 0) write_reg(REG_REUSE, reuse);
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_IDLE_DAYS, ($urandom_range(0, 5) == 0) ?
                    CFG_W'($urandom_range(0, 255)) : CFG_W'($urandom_range(0, 4)));
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_DRAIN_EN, CFG_W'($urandom_range(0, 4) != 0));
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_IDX_W'(REG_DRAIN_EN + $urandom_range(1, 3)), CFG_W'($urandom));
            wide_last = wide;

            case ($urandom_range(0, 3))
                0:       act_pct = 0;
                1:       act_pct = 10;
                2:       act_pct = 50;
                default: act_pct = 90;
            endcase
            ok_pct   = ($urandom_range(0, 1) == 0) ? 80 : 40;
            smooth   = ($urandom_range(0, 3) == 0);
            burst    = $urandom_range(40, 120);
            pause_at = ($urandom_range(0, 2) == 0) ? $urandom_range(1, burst - 1) : -1;
            for (int i = 0; i < burst; i++) begin
                // mid-phase hold-off until every owed result is back
                if (i == pause_at) settle_timer();
                send_tick($urandom_range(0, 99) < act_pct, $urandom_range(0, 99) < ok_pct);
            end
            sent += burst;
            settle_timer();
            smooth = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_idx             = '0;
        cfg_data            = '0;
        in_if.valid         = 1'b0;
        in_if.user_active   = 1'b0;
        in_if.conditions_ok = 1'b0;
        out_if.ready        = 1'b0;
        mismatches    = 0;
        ticks_sent    = 0;
        results_seen  = 0;
        expiries_seen = 0;
        drains_seen   = 0;
        smooth        = 1'b0;
        timer_reset();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_power_on_defaults();
        test_expiry_drain();
        test_early_start();
        test_register_extremes();
        test_random_intervals(RANDOM_TICKS);

        settle_timer();
        if (due_results.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", due_results.size()));

        $display("drain_interval_timer_core_tb: %0d ticks sent, %0d results checked",
            ticks_sent, results_seen);
        $display("drain_interval_timer_core_tb: %0d interval expiries, %0d drain starts, %0d mismatches",
            expiries_seen, drains_seen, mismatches);
        if (mismatches == 0)
            $display("drain_interval_timer_core_tb: done, clean");
        else
            $display("drain_interval_timer_core_tb: done, errors");
        $finish;
    end

    // hard stop if the handshake ever hangs
    initial begin
        #400000;
        $display("drain_interval_timer_core_tb: done, errors");
        $finish;
    end

endmodule : drain_interval_timer_core_tb
